FILE: sv/tsmp_pkg.sv
// Package for the terminal SGR mouse parser: byte codes, token classes,
// and the token and result types shared by the front, back and top level.
// No dependencies.
`timescale 1ns / 1ps

package tsmp_pkg;

  localparam int FIELD_WIDTH_DEF = 16;
  localparam int TOK_DEPTH_DEF   = 4;
  localparam int RES_DEPTH_DEF   = 4;
  localparam int OUT_WIDTH       = 16;

  localparam logic [7:0] BYTE_ESC     = 8'h1B;
  localparam logic [7:0] BYTE_LBRACK  = 8'h5B;
  localparam logic [7:0] BYTE_LT      = 8'h3C;
  localparam logic [7:0] BYTE_PRESS   = 8'h4D;
  localparam logic [7:0] BYTE_RELEASE = 8'h6D;
  localparam logic [7:0] BYTE_SEMI    = 8'h3B;
  localparam logic [7:0] BYTE_ZERO    = 8'h30;
  localparam logic [7:0] BYTE_NINE    = 8'h39;
  localparam logic [7:0] FINAL_LO     = 8'h40;
  localparam logic [7:0] FINAL_HI     = 8'h7E;

  localparam logic [2:0] CLS_OTHER   = 3'd0;
  localparam logic [2:0] CLS_ESC     = 3'd1;
  localparam logic [2:0] CLS_LBRACK  = 3'd2;
  localparam logic [2:0] CLS_LT      = 3'd3;
  localparam logic [2:0] CLS_PRESS   = 3'd4;
  localparam logic [2:0] CLS_RELEASE = 3'd5;
  localparam logic [2:0] CLS_SEMI    = 3'd6;
  localparam logic [2:0] CLS_DIGIT   = 3'd7;

  typedef struct packed {
    logic [2:0] cls;
    logic       is_final;
    logic [3:0] digit;
    logic [7:0] data;
  } token_t;

  typedef struct packed {
    logic                 event_kind;
    logic [7:0]           key_code;
    logic [OUT_WIDTH-1:0] button;
    logic [OUT_WIDTH-1:0] column;
    logic [OUT_WIDTH-1:0] row_number;
  } result_t;

endpackage

FILE: sv/tsmp_fifo.sv
// Small register-based FIFO used between the front and back and on the
// result side. Generic width and depth; no package dependency.
`timescale 1ns / 1ps

module tsmp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: sv/tsmp_front.sv
// Front of the parser: accepts input bytes and classifies each into a token
// for the token queue. Depends on tsmp_pkg.
`timescale 1ns / 1ps

module tsmp_front (
  input  logic              push,
  input  logic [7:0]        in_byte,
  input  logic              q_full,
  output logic              full,
  output logic              q_push,
  output tsmp_pkg::token_t  token
);

  import tsmp_pkg::*;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    token.data     = in_byte;
    token.is_final = (in_byte >= FINAL_LO) && (in_byte <= FINAL_HI);
    token.digit    = in_byte[3:0];
    if (in_byte inside {[BYTE_ZERO:BYTE_NINE]}) begin
      token.cls = CLS_DIGIT;
    end else begin
      case (in_byte)
        BYTE_ESC:     token.cls = CLS_ESC;
        BYTE_LBRACK:  token.cls = CLS_LBRACK;
        BYTE_LT:      token.cls = CLS_LT;
        BYTE_PRESS:   token.cls = CLS_PRESS;
        BYTE_RELEASE: token.cls = CLS_RELEASE;
        BYTE_SEMI:    token.cls = CLS_SEMI;
        default:      token.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

FILE: sv/tsmp_back.sv
// Back of the parser: takes one token a cycle from the token queue while the
// result queue is not full, runs the escape and SGR state machine and writes
// events to the result queue. Depends on tsmp_pkg.
`timescale 1ns / 1ps

module tsmp_back #(
  parameter int FIELD_WIDTH = tsmp_pkg::FIELD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tsmp_pkg::token_t  tok,
  input  logic              tok_empty,
  output logic              tok_pop,
  input  logic              res_full,
  output logic              res_push,
  output tsmp_pkg::result_t res
);

  import tsmp_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_CSI  = 3'd2;
  localparam logic [2:0] PH_SKIP = 3'd3;
  localparam logic [2:0] PH_SGR  = 3'd4;

  localparam logic [1:0] LAST_FIELD = 2'd2;

  logic [2:0]             phase;
  logic [2:0]             phase_next;
  logic [1:0]             field_index;
  logic [1:0]             field_index_next;
  logic                   digit_seen;
  logic                   digit_seen_next;
  logic [FIELD_WIDTH-1:0] fields [3];
  logic                   clear_fields;
  logic                   load_digit;
  logic [FIELD_WIDTH-1:0] cur;
  logic [FIELD_WIDTH+3:0] prod;
  logic [FIELD_WIDTH-1:0] sat;
  logic [FIELD_WIDTH+OUT_WIDTH-1:0] ext [3];
  logic                   emit_key;
  logic                   emit_click;
  logic                   go;

  assign go       = !tok_empty && !res_full;
  assign tok_pop  = go;
  assign res_push = go && (emit_key || emit_click);

  assign cur  = fields[field_index];
  assign prod = ({4'b0, cur} << 3) + ({4'b0, cur} << 1)
              + {{FIELD_WIDTH{1'b0}}, tok.digit};
  assign sat  = (|prod[FIELD_WIDTH+3:FIELD_WIDTH]) ? '1 : prod[FIELD_WIDTH-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = {{OUT_WIDTH{1'b0}}, fields[i]};
    end
  end

  always_comb begin
    phase_next       = phase;
    field_index_next = field_index;
    digit_seen_next  = digit_seen;
    clear_fields     = 1'b0;
    load_digit       = 1'b0;
    emit_key         = 1'b0;
    emit_click       = 1'b0;
    case (phase)
      PH_ESC: begin
        if (tok.cls == CLS_LBRACK) begin
          phase_next = PH_CSI;
        end else if (tok.cls == CLS_ESC) begin
          phase_next = PH_ESC;
        end else begin
          phase_next = PH_IDLE;
          emit_key   = 1'b1;
        end
      end
      PH_CSI: begin
        if (tok.cls == CLS_LT) begin
          clear_fields     = 1'b1;
          field_index_next = '0;
          digit_seen_next  = 1'b0;
          phase_next       = PH_SGR;
        end else if (tok.is_final) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (tok.is_final) begin
          phase_next = PH_IDLE;
        end
      end
      PH_SGR: begin
        case (tok.cls)
          CLS_PRESS, CLS_RELEASE: begin
            phase_next = PH_IDLE;
            emit_click = (tok.cls == CLS_PRESS) && (field_index == LAST_FIELD)
                       && digit_seen;
          end
          CLS_SEMI: begin
            if (field_index >= LAST_FIELD) begin
              phase_next = PH_IDLE;
            end else begin
              field_index_next = field_index + 1'b1;
              digit_seen_next  = 1'b0;
            end
          end
          CLS_DIGIT: begin
            load_digit      = 1'b1;
            digit_seen_next = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: begin
        if (tok.cls == CLS_ESC) begin
          phase_next = PH_ESC;
        end else begin
          phase_next = PH_IDLE;
          emit_key   = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    res.event_kind = emit_click;
    res.key_code   = emit_key ? tok.data : 8'h00;
    res.button     = emit_click ? ext[0][OUT_WIDTH-1:0] : '0;
    res.column     = emit_click ? ext[1][OUT_WIDTH-1:0] : '0;
    res.row_number = emit_click ? ext[2][OUT_WIDTH-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      field_index <= '0;
      digit_seen  <= 1'b0;
    end else if (go) begin
      phase       <= phase_next;
      field_index <= field_index_next;
      digit_seen  <= digit_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && clear_fields) begin
      for (int i = 0; i < 3; i++) begin
        fields[i] <= '0;
      end
    end else if (go && load_digit) begin
      fields[field_index] <= sat;
    end
  end

endmodule

FILE: sv/terminal_sgr_mouse_parser_top.sv
// Top level of the terminal SGR mouse parser: front classifier, token queue,
// parser back end and result queue. Depends on tsmp_pkg and the submodules.
//
//   Channel   Handshake          Fields
//   input     push / full        in_byte
//   result    pop / empty        event_kind, key_code, button, column, row_number
//
// One byte is taken per cycle while full is low; an accepted byte is registered
// in the token queue, and any event it yields is registered in the result queue.
// Each queue holds four entries by default; full and empty come from their counts.
// Reset clears both queues and the parser state.
// A stalled result side fills the result queue, then the token queue, then
// raises full.
`timescale 1ns / 1ps

module terminal_sgr_mouse_parser_top #(
  parameter int FIELD_WIDTH = tsmp_pkg::FIELD_WIDTH_DEF,
  parameter int TOK_DEPTH   = tsmp_pkg::TOK_DEPTH_DEF,
  parameter int RES_DEPTH   = tsmp_pkg::RES_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic        event_kind,
  output logic [7:0]  key_code,
  output logic [15:0] button,
  output logic [15:0] column,
  output logic [15:0] row_number
);

  import tsmp_pkg::*;

  token_t  tok_in;
  token_t  tok_out;
  logic    tok_push;
  logic    tok_pop;
  logic    tok_full;
  logic    tok_empty;
  result_t res_in;
  result_t res_out;
  logic    res_push;
  logic    res_full;

  tsmp_front u_front (
    .push    (push),
    .in_byte (in_byte),
    .q_full  (tok_full),
    .full    (full),
    .q_push  (tok_push),
    .token   (tok_in)
  );

  tsmp_fifo #(
    .WIDTH ($bits(token_t)),
    .DEPTH (TOK_DEPTH)
  ) u_tok_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (tok_push),
    .wdata (tok_in),
    .rd    (tok_pop),
    .rdata (tok_out),
    .full  (tok_full),
    .empty (tok_empty)
  );

  tsmp_back #(
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok_out),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  tsmp_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_in),
    .rd    (pop),
    .rdata (res_out),
    .full  (res_full),
    .empty (empty)
  );

  assign event_kind = res_out.event_kind;
  assign key_code   = res_out.key_code;
  assign button     = res_out.button;
  assign column     = res_out.column;
  assign row_number = res_out.row_number;

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result written while result queue is full");

  a_tok_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    tok_pop |-> !tok_empty)
    else $error("token taken from an empty queue");

  a_click_no_key: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_kind) |-> (key_code == 8'h00))
    else $error("click event carries a key code");

  a_key_no_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && !event_kind) |-> (button == '0 && column == '0 && row_number == '0))
    else $error("key event carries mouse fields");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule
